[hw/rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants and types of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MIN_BLOCK_BYTES_DEF = 256;
  localparam int MAX_LEVELS_DEF      = 12;
  localparam int POOL_LEVELS_RST     = 12;

  localparam int WORD_W = 32;
  localparam int CFG_W  = 4;
  localparam int OFF_W  = 19;
  localparam int SIZE_W = 20;
  localparam int CNT_W  = 32;
  localparam int DIV_W  = SIZE_W + 1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SIZE   = 2'd1,
    ST_NO_MEM     = 2'd2,
    ST_BAD_OFFSET = 2'd3
  } status_e;

  typedef enum logic [17:0] {
    S_CLR   = 18'h00001,
    S_IDLE  = 18'h00002,
    S_DIV   = 18'h00004,
    S_LVL   = 18'h00008,
    S_SRD   = 18'h00010,
    S_SCHK  = 18'h00020,
    S_SPLIT = 18'h00040,
    S_SPRD  = 18'h00080,
    S_SPWR  = 18'h00100,
    S_AVRD  = 18'h00200,
    S_AVWR  = 18'h00400,
    S_RCHK  = 18'h00800,
    S_RVAL  = 18'h01000,
    S_MRD   = 18'h02000,
    S_MCHK  = 18'h04000,
    S_STRD  = 18'h08000,
    S_STWR  = 18'h10000,
    S_OUT   = 18'h20000
  } state_e;

endpackage

[hw/rtl/buddy_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator for one pool of MIN_BLOCK_BYTES << (levels - 1) bytes.
// Input channel (in_valid_i/in_ready_o) takes one allocate or release item;
// output channel (out_valid_o/out_ready_i) returns one result item per input.
// Config channel (cfg_valid_i/cfg_ready_o) sets the level count and restarts
// the pool; it is taken only while the block is idle.
// Free maps live in a word memory of WORD_W bits, walked by one sequencer.
// Allocate: a bit-serial divider rounds the size up to the alignment, size compares
// pick the level, free map words are scanned, the found block is split, then finish.
// Release: offset and slot checks, buddy merges while the buddy is free, then finish.
// One item is in work at a time; in_ready_o is high only when idle.
// After reset and after each config write a clearing pass sweeps the free map
// and valid word memories; no item is taken meanwhile.
// The result register holds a finished item while the receiver stalls; the
// next item is taken meanwhile and waits in its last state until it is free.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF,
  parameter int MAX_LEVELS      = MAX_LEVELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_pool_levels_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [SIZE_W-1:0] request_size_i,
  input  logic [SIZE_W-1:0] alignment_i,
  input  logic [OFF_W-1:0]  release_offset_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [OFF_W-1:0]  granted_offset_o,
  output logic [SIZE_W-1:0] granted_size_o,
  output logic [SIZE_W-1:0] bytes_in_use_o,
  output logic [SIZE_W-1:0] bytes_available_o,
  output logic [SIZE_W-1:0] peak_bytes_o,
  output logic [CNT_W-1:0]  allocation_count_o,
  output logic [CNT_W-1:0]  release_count_o
);

  localparam int LOG_MIN    = $clog2(MIN_BLOCK_BYTES);
  localparam int LW         = $clog2(WORD_W);
  localparam int SLOT_W     = MAX_LEVELS - 1;
  localparam int IDX_W      = (SLOT_W > LW) ? SLOT_W : LW;
  localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
  localparam int BYTE_W     = LOG_MIN + MAX_LEVELS;
  localparam int CMP_W      = (BYTE_W > DIV_W) ? BYTE_W : DIV_W;
  localparam int FULL_LVLS  = (MAX_LEVELS > LW) ? MAX_LEVELS - LW : 0;
  localparam int FULL_WORDS = (MAX_LEVELS > LW) ? (1 << (MAX_LEVELS - LW)) : 1;
  localparam int FW_DEPTH   = FULL_WORDS - 1 + MAX_LEVELS - FULL_LVLS;
  localparam int FW_AW      = $clog2(FW_DEPTH);
  localparam int VW_DEPTH   = (SLOT_W > LW) ? (1 << (SLOT_W - LW)) : 1;
  localparam int VW_AW      = (VW_DEPTH > 1) ? $clog2(VW_DEPTH) : 1;
  localparam int SLOTS      = 1 << SLOT_W;
  localparam int RST_LEVELS = (POOL_LEVELS_RST > MAX_LEVELS) ? MAX_LEVELS : POOL_LEVELS_RST;
  localparam int DCNT_W     = $clog2(DIV_W);

  localparam logic [WORD_W-1:0] WORD_ONE = WORD_W'(1);
  localparam logic [BYTE_W-1:0] RST_POOL =
    BYTE_W'(MIN_BLOCK_BYTES) << (RST_LEVELS - 1);

  function automatic logic [FW_AW-1:0] lvl_base(input logic [LVL_W-1:0] lvl);
    int l;
    int b;
    l = int'(lvl);
    if (l <= FULL_LVLS) begin
      b = FULL_WORDS - (FULL_WORDS >> l);
    end else begin
      b = FULL_WORDS - 1 + l - FULL_LVLS;
    end
    return FW_AW'(b);
  endfunction

  function automatic logic [LVL_W-1:0] clamp_levels(input logic [CFG_W-1:0] v);
    logic [LVL_W-1:0] r;
    if (v == '0) begin
      r = LVL_W'(1);
    end else if (int'(v) > MAX_LEVELS) begin
      r = LVL_W'(MAX_LEVELS);
    end else begin
      r = LVL_W'(v);
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [LVL_W-1:0]  levels_q, levels_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [LVL_W-1:0]  req_q, req_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  w_q, w_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [SIZE_W-1:0] align_q, align_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [DIV_W-1:0]  sh_q, sh_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [FW_AW-1:0]  clr_q, clr_d;
  logic [BYTE_W-1:0] in_use_q, in_use_d;
  logic [BYTE_W-1:0] free_q, free_d;
  logic [BYTE_W-1:0] peak_q, peak_d;
  logic [CNT_W-1:0]  acnt_q, acnt_d;
  logic [CNT_W-1:0]  rcnt_q, rcnt_d;
  status_e           res_st_q, res_st_d;
  logic [BYTE_W-1:0] res_off_q, res_off_d;
  logic [BYTE_W-1:0] res_sz_q, res_sz_d;
  logic              ovalid_q, ovalid_d;
  status_e           ost_q, ost_d;
  logic [OFF_W-1:0]  ooff_q, ooff_d;
  logic [SIZE_W-1:0] osz_q, osz_d;
  logic [SIZE_W-1:0] ouse_q, ouse_d;
  logic [SIZE_W-1:0] oavl_q, oavl_d;
  logic [SIZE_W-1:0] opk_q, opk_d;
  logic [CNT_W-1:0]  oac_q, oac_d;
  logic [CNT_W-1:0]  orc_q, orc_d;

  logic [WORD_W-1:0] fw_mem [FW_DEPTH];
  logic [WORD_W-1:0] vw_mem [VW_DEPTH];
  logic [LVL_W-1:0]  lv_mem [SLOTS];
  logic [WORD_W-1:0] fw_rd_q, vw_rd_q;
  logic [LVL_W-1:0]  lv_rd_q;

  logic              fw_we, vw_we, lv_we;
  logic [WORD_W-1:0] fw_wdata, vw_wdata;
  logic [FW_AW-1:0]  fw_addr, base;
  logic [VW_AW-1:0]  vw_addr;
  logic [SLOT_W-1:0] lv_addr;
  logic [LVL_W-1:0]  base_lvl;
  logic              flip;
  logic [IDX_W-1:0]  acc_idx, slot_sel, last_w, found_idx;
  logic [WORD_W-1:0] fw_mask, vw_mask;
  logic [LW-1:0]     pe;
  logic [DIV_W-1:0]  dividend, rounded, trial;
  logic [CMP_W-1:0]  lvl_bytes, pool_bytes;
  logic [BYTE_W-1:0] blk_bytes, rel_bytes, new_use, pool_b;
  logic [LVL_W-1:0]  new_levels;
  logic [SIZE_W-1:0] align_in;

  assign flip = (state_q == S_SPRD) || (state_q == S_SPWR) ||
                (state_q == S_MRD) || (state_q == S_MCHK);
  assign acc_idx  = idx_q ^ IDX_W'(flip);
  assign fw_mask  = WORD_ONE << acc_idx[LW-1:0];
  assign slot_sel = ((state_q == S_AVRD) || (state_q == S_AVWR)) ? (idx_q << lvl_q) : idx_q;
  assign vw_mask  = WORD_ONE << slot_sel[LW-1:0];
  assign base_lvl = (state_q == S_CLR) ? levels_q - LVL_W'(1) : lvl_q;
  assign base     = lvl_base(base_lvl);
  assign last_w   = IDX_W'((((IDX_W + 1)'(1) << (levels_q - LVL_W'(1) - lvl_q))
                    - (IDX_W + 1)'(1)) >> LW);
  assign found_idx = IDX_W'({w_q, pe});
  assign dividend  = DIV_W'(size_q) + DIV_W'(align_q) - DIV_W'(1);
  assign rounded   = dividend - DIV_W'(rem_q);
  assign trial     = {rem_q, sh_q[DIV_W-1]};
  assign lvl_bytes = CMP_W'(MIN_BLOCK_BYTES) << lvl_q;
  assign pool_bytes = CMP_W'(MIN_BLOCK_BYTES) << (levels_q - LVL_W'(1));
  assign pool_b    = BYTE_W'(MIN_BLOCK_BYTES) << (levels_q - LVL_W'(1));
  assign blk_bytes = BYTE_W'(MIN_BLOCK_BYTES) << lvl_q;
  assign rel_bytes = BYTE_W'(MIN_BLOCK_BYTES) << lv_rd_q;
  assign new_use   = in_use_q + blk_bytes;
  assign new_levels = clamp_levels(cfg_pool_levels_i);
  assign align_in  = (alignment_i == '0) ? SIZE_W'(1) : alignment_i;

  always_comb begin
    pe = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (fw_rd_q[i]) begin
        pe = LW'(i);
      end
    end
  end

  always_comb begin
    case (state_q)
      S_CLR:        fw_addr = clr_q;
      S_SRD, S_SCHK: fw_addr = base + FW_AW'(w_q);
      default:      fw_addr = base + FW_AW'(acc_idx >> LW);
    endcase
    vw_addr = (state_q == S_CLR) ? VW_AW'(clr_q) : VW_AW'(slot_sel >> LW);
    lv_addr = SLOT_W'(slot_sel);
  end

  always_ff @(posedge clk_i) begin
    if (fw_we) begin
      fw_mem[fw_addr] <= fw_wdata;
    end
    fw_rd_q <= fw_mem[fw_addr];
  end

  always_ff @(posedge clk_i) begin
    if (vw_we) begin
      vw_mem[vw_addr] <= vw_wdata;
    end
    vw_rd_q <= vw_mem[vw_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lv_we) begin
      lv_mem[lv_addr] <= lvl_q;
    end
    lv_rd_q <= lv_mem[lv_addr];
  end

  always_comb begin
    state_d   = state_q;
    levels_d  = levels_q;
    lvl_d     = lvl_q;
    req_d     = req_q;
    idx_d     = idx_q;
    w_d       = w_q;
    size_d    = size_q;
    align_d   = align_q;
    off_d     = off_q;
    sh_d      = sh_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    clr_d     = clr_q;
    in_use_d  = in_use_q;
    free_d    = free_q;
    peak_d    = peak_q;
    acnt_d    = acnt_q;
    rcnt_d    = rcnt_q;
    res_st_d  = res_st_q;
    res_off_d = res_off_q;
    res_sz_d  = res_sz_q;
    ovalid_d  = ovalid_q;
    ost_d     = ost_q;
    ooff_d    = ooff_q;
    osz_d     = osz_q;
    ouse_d    = ouse_q;
    oavl_d    = oavl_q;
    opk_d     = opk_q;
    oac_d     = oac_q;
    orc_d     = orc_q;
    fw_we     = 1'b0;
    fw_wdata  = fw_rd_q;
    vw_we     = 1'b0;
    vw_wdata  = vw_rd_q;
    lv_we     = 1'b0;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        fw_we    = 1'b1;
        fw_wdata = (clr_q == base) ? WORD_ONE : '0;
        if (int'(clr_q) < VW_DEPTH) begin
          vw_we    = 1'b1;
          vw_wdata = '0;
        end
        if (clr_q == FW_AW'(FW_DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + FW_AW'(1);
        end
      end
      S_IDLE: begin
        if (cfg_valid_i) begin
          levels_d = new_levels;
          in_use_d = '0;
          free_d   = BYTE_W'(MIN_BLOCK_BYTES) << (new_levels - LVL_W'(1));
          peak_d   = '0;
          acnt_d   = '0;
          rcnt_d   = '0;
          clr_d    = '0;
          state_d  = S_CLR;
        end else if (in_valid_i) begin
          if (operation_i == OP_RELEASE) begin
            off_d   = release_offset_i;
            idx_d   = IDX_W'(release_offset_i >> LOG_MIN);
            state_d = S_RCHK;
          end else if (request_size_i == '0) begin
            res_st_d  = ST_BAD_SIZE;
            res_off_d = '0;
            res_sz_d  = '0;
            state_d   = S_OUT;
          end else begin
            size_d  = request_size_i;
            align_d = align_in;
            sh_d    = DIV_W'(request_size_i) + DIV_W'(align_in) - DIV_W'(1);
            rem_d   = '0;
            dcnt_d  = '0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (trial >= DIV_W'(align_q)) begin
          rem_d = SIZE_W'(trial - DIV_W'(align_q));
        end else begin
          rem_d = SIZE_W'(trial);
        end
        sh_d = sh_q << 1;
        if (dcnt_q == DCNT_W'(DIV_W - 1)) begin
          lvl_d   = '0;
          state_d = S_LVL;
        end else begin
          dcnt_d = dcnt_q + DCNT_W'(1);
        end
      end
      S_LVL: begin
        if (lvl_q >= levels_q) begin
          res_st_d  = ST_BAD_SIZE;
          res_off_d = '0;
          res_sz_d  = '0;
          state_d   = S_OUT;
        end else if (CMP_W'(rounded) <= lvl_bytes) begin
          req_d   = lvl_q;
          w_d     = '0;
          state_d = S_SRD;
        end else begin
          lvl_d = lvl_q + LVL_W'(1);
        end
      end
      S_SRD: begin
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (fw_rd_q != '0) begin
          fw_we    = 1'b1;
          fw_wdata = fw_rd_q & ~(WORD_ONE << pe);
          idx_d    = found_idx;
          state_d  = S_SPLIT;
        end else if (w_q == last_w) begin
          if ((LVL_W + 1)'(lvl_q) + (LVL_W + 1)'(1) >= (LVL_W + 1)'(levels_q)) begin
            res_st_d  = ST_NO_MEM;
            res_off_d = '0;
            res_sz_d  = '0;
            state_d   = S_OUT;
          end else begin
            lvl_d   = lvl_q + LVL_W'(1);
            w_d     = '0;
            state_d = S_SRD;
          end
        end else begin
          w_d     = w_q + IDX_W'(1);
          state_d = S_SRD;
        end
      end
      S_SPLIT: begin
        if (lvl_q == req_q) begin
          state_d = S_AVRD;
        end else begin
          lvl_d   = lvl_q - LVL_W'(1);
          idx_d   = idx_q << 1;
          state_d = S_SPRD;
        end
      end
      S_SPRD: begin
        state_d = S_SPWR;
      end
      S_SPWR: begin
        fw_we    = 1'b1;
        fw_wdata = fw_rd_q | fw_mask;
        state_d  = S_SPLIT;
      end
      S_AVRD: begin
        state_d = S_AVWR;
      end
      S_AVWR: begin
        vw_we     = 1'b1;
        vw_wdata  = vw_rd_q | vw_mask;
        lv_we     = 1'b1;
        res_st_d  = ST_OK;
        res_off_d = BYTE_W'(slot_sel) << LOG_MIN;
        res_sz_d  = blk_bytes;
        in_use_d  = new_use;
        free_d    = free_q - blk_bytes;
        acnt_d    = acnt_q + CNT_W'(1);
        if (new_use > peak_q) begin
          peak_d = new_use;
        end
        state_d = S_OUT;
      end
      S_RCHK: begin
        if ((off_q[LOG_MIN-1:0] != '0) || (CMP_W'(off_q) >= pool_bytes)) begin
          res_st_d  = ST_BAD_OFFSET;
          res_off_d = '0;
          res_sz_d  = '0;
          state_d   = S_OUT;
        end else begin
          state_d = S_RVAL;
        end
      end
      S_RVAL: begin
        if (((vw_rd_q & vw_mask) == '0) || (lv_rd_q >= levels_q)) begin
          res_st_d  = ST_BAD_OFFSET;
          res_off_d = '0;
          res_sz_d  = '0;
          state_d   = S_OUT;
        end else begin
          vw_we     = 1'b1;
          vw_wdata  = vw_rd_q & ~vw_mask;
          lvl_d     = lv_rd_q;
          idx_d     = idx_q >> lv_rd_q;
          res_st_d  = ST_OK;
          res_off_d = BYTE_W'(off_q);
          res_sz_d  = rel_bytes;
          in_use_d  = in_use_q - rel_bytes;
          free_d    = free_q + rel_bytes;
          rcnt_d    = rcnt_q + CNT_W'(1);
          state_d   = S_MRD;
        end
      end
      S_MRD: begin
        if ((LVL_W + 1)'(lvl_q) + (LVL_W + 1)'(1) >= (LVL_W + 1)'(levels_q)) begin
          state_d = S_STRD;
        end else begin
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        if ((fw_rd_q & fw_mask) != '0) begin
          fw_we    = 1'b1;
          fw_wdata = fw_rd_q & ~fw_mask;
          idx_d    = idx_q >> 1;
          lvl_d    = lvl_q + LVL_W'(1);
          state_d  = S_MRD;
        end else begin
          state_d = S_STRD;
        end
      end
      S_STRD: begin
        state_d = S_STWR;
      end
      S_STWR: begin
        fw_we    = 1'b1;
        fw_wdata = fw_rd_q | fw_mask;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ost_d    = res_st_q;
          ooff_d   = OFF_W'(res_off_q);
          osz_d    = SIZE_W'(res_sz_q);
          ouse_d   = SIZE_W'(in_use_q);
          oavl_d   = SIZE_W'(free_q);
          opk_d    = SIZE_W'(peak_q);
          oac_d    = acnt_q;
          orc_d    = rcnt_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      levels_q <= LVL_W'(RST_LEVELS);
      clr_q    <= '0;
      in_use_q <= '0;
      free_q   <= RST_POOL;
      peak_q   <= '0;
      acnt_q   <= '0;
      rcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      levels_q <= levels_d;
      clr_q    <= clr_d;
      in_use_q <= in_use_d;
      free_q   <= free_d;
      peak_q   <= peak_d;
      acnt_q   <= acnt_d;
      rcnt_q   <= rcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q     <= lvl_d;
    req_q     <= req_d;
    idx_q     <= idx_d;
    w_q       <= w_d;
    size_q    <= size_d;
    align_q   <= align_d;
    off_q     <= off_d;
    sh_q      <= sh_d;
    rem_q     <= rem_d;
    dcnt_q    <= dcnt_d;
    res_st_q  <= res_st_d;
    res_off_q <= res_off_d;
    res_sz_q  <= res_sz_d;
    ost_q     <= ost_d;
    ooff_q    <= ooff_d;
    osz_q     <= osz_d;
    ouse_q    <= ouse_d;
    oavl_q    <= oavl_d;
    opk_q     <= opk_d;
    oac_q     <= oac_d;
    orc_q     <= orc_d;
  end

  assign cfg_ready_o        = (state_q == S_IDLE);
  assign in_ready_o         = (state_q == S_IDLE) && !cfg_valid_i;
  assign out_valid_o        = ovalid_q;
  assign status_o           = ost_q;
  assign granted_offset_o   = ooff_q;
  assign granted_size_o     = osz_q;
  assign bytes_in_use_o     = ouse_q;
  assign bytes_available_o  = oavl_q;
  assign peak_bytes_o       = opk_q;
  assign allocation_count_o = oac_q;
  assign release_count_o    = orc_q;

`ifndef SYNTHESIS
  a_bytes_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |->
      ((BYTE_W + 1)'(in_use_q) + (BYTE_W + 1)'(free_q) == (BYTE_W + 1)'(pool_b)))
    else $error("in use plus free bytes differ from pool size");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= in_use_q)
    else $error("peak bytes below bytes in use");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready again right after an item");
`endif

endmodule

[tb/buddy_block_allocator_unit_test.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit_test
// Self-checking bench for the buddy block allocator. A directed table covers
// size and offset extremes and every status code, then random allocate and
// release traffic runs at several level counts with a bit-level model of the
// free maps, under random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit_test;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MINB   = MIN_BLOCK_BYTES_DEF;
  localparam int MAXL   = MAX_LEVELS_DEF;
  localparam int NODES  = (1 << MAXL) - 1;
  localparam int SLOTS  = 1 << (MAXL - 1);
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    status_e           st;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] sz;
    logic [SIZE_W-1:0] used;
    logic [SIZE_W-1:0] avail;
    logic [SIZE_W-1:0] peak;
    logic [CNT_W-1:0]  acnt;
    logic [CNT_W-1:0]  rcnt;
  } grant_t;

  typedef struct {
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] align;
    logic [OFF_W-1:0]  off;
    bit                typed;
    status_e           st;
    logic [OFF_W-1:0]  goff;
    logic [SIZE_W-1:0] gsz;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_pool_levels_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              operation_i = OP_ALLOC;
  logic [SIZE_W-1:0] request_size_i = '0;
  logic [SIZE_W-1:0] alignment_i = '0;
  logic [OFF_W-1:0]  release_offset_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        status_o;
  logic [OFF_W-1:0]  granted_offset_o;
  logic [SIZE_W-1:0] granted_size_o;
  logic [SIZE_W-1:0] bytes_in_use_o;
  logic [SIZE_W-1:0] bytes_available_o;
  logic [SIZE_W-1:0] peak_bytes_o;
  logic [CNT_W-1:0]  allocation_count_o;
  logic [CNT_W-1:0]  release_count_o;

  buddy_block_allocator_unit DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // allocator model state
  bit          free_bits [NODES];
  bit          slot_used [SLOTS];
  int unsigned slot_lvl  [SLOTS];
  int unsigned lvls;
  longint      in_use, avail_b, peak_b;
  logic [CNT_W-1:0] allocs, releases;

  grant_t      pending_grants [$];
  int unsigned live_offsets [$];
  int          errors = 0;
  int          tx_idle = 0, rx_idle = 0;
  bit          hold_go = 0;
  int          hold_left = 0;
  int          stall_cycles = 0;

  function automatic int node_at(int unsigned l, longint idx);
    return ((1 << (MAXL - 1 - l)) - 1) + int'(idx);
  endfunction

  function automatic longint lvl_bytes(int unsigned l);
    return longint'(MINB) << l;
  endfunction

  function automatic void pool_restart(logic [CFG_W-1:0] v);
    lvls = (v < 1) ? 1 : (v > MAXL) ? MAXL : v;
    foreach (free_bits[i]) free_bits[i] = 0;
    foreach (slot_used[i]) slot_used[i] = 0;
    free_bits[node_at(lvls - 1, 0)] = 1;
    in_use = 0;
    avail_b = lvl_bytes(lvls - 1);
    peak_b = 0;
    allocs = '0;
    releases = '0;
    live_offsets.delete();
  endfunction

  function automatic grant_t predict_grant(logic op, logic [SIZE_W-1:0] size_in,
                                           logic [SIZE_W-1:0] align_in,
                                           logic [OFF_W-1:0] roff);
    grant_t g;
    longint sz, al, off, idx, n, bsz;
    int unsigned req, l;
    bit found;
    int slot;
    g = '0;
    g.st = ST_OK;
    off = 0;
    bsz = 0;
    if (op == OP_ALLOC) begin
      sz = size_in;
      al = (align_in == 0) ? 1 : align_in;
      found = 0;
      if (sz == 0) g.st = ST_BAD_SIZE;
      else begin
        sz = ((sz + al - 1) / al) * al;
        req = 0;
        while (req < lvls && sz > lvl_bytes(req)) req++;
        if (req >= lvls) g.st = ST_BAD_SIZE;
        else begin
          l = req;
          idx = 0;
          while (l < lvls && !found) begin
            n = longint'(1) << (lvls - 1 - l);
            for (idx = 0; idx < n; idx++)
              if (free_bits[node_at(l, idx)]) begin
                found = 1;
                break;
              end
            if (!found) l++;
          end
          if (!found) g.st = ST_NO_MEM;
          else begin
            free_bits[node_at(l, idx)] = 0;
            while (l > req) begin
              l--;
              idx = idx << 1;
              free_bits[node_at(l, idx + 1)] = 1;
            end
            bsz = lvl_bytes(req);
            off = idx * bsz;
            slot = int'(off / MINB);
            slot_used[slot] = 1;
            slot_lvl[slot] = req;
            in_use += bsz;
            avail_b -= bsz;
            allocs++;
            if (in_use > peak_b) peak_b = in_use;
            live_offsets = {live_offsets, int'(off)};
          end
        end
      end
    end else begin
      off = roff;
      slot = int'(off / MINB);
      if ((off % MINB) != 0 || off >= lvl_bytes(lvls - 1) || !slot_used[slot] ||
          slot_lvl[slot] >= lvls) g.st = ST_BAD_OFFSET;
      else begin
        l = slot_lvl[slot];
        slot_used[slot] = 0;
        bsz = lvl_bytes(l);
        in_use -= bsz;
        avail_b += bsz;
        releases++;
        idx = off / bsz;
        while (l + 1 < lvls && free_bits[node_at(l, idx ^ 1)]) begin
          free_bits[node_at(l, idx ^ 1)] = 0;
          idx = idx >> 1;
          l++;
        end
        free_bits[node_at(l, idx)] = 1;
        foreach (live_offsets[i])
          if (live_offsets[i] == roff) begin
            live_offsets.delete(i);
            break;
          end
      end
    end
    if (g.st != ST_OK) begin
      off = 0;
      bsz = 0;
    end
    g.off = off[OFF_W-1:0];
    g.sz = bsz[SIZE_W-1:0];
    g.used = in_use[SIZE_W-1:0];
    g.avail = avail_b[SIZE_W-1:0];
    g.peak = peak_b[SIZE_W-1:0];
    g.acnt = allocs;
    g.rcnt = releases;
    return g;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver side: random ready plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_left = 400;
      hold_go = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    grant_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected item", status_o, -1);
      end else begin
        w = pending_grants.pop_front();
        if (status_o !== w.st) report_mismatch("status", status_o, w.st);
        if (granted_offset_o !== w.off) report_mismatch("offset", granted_offset_o, w.off);
        if (granted_size_o !== w.sz) report_mismatch("size", granted_size_o, w.sz);
        if (bytes_in_use_o !== w.used) report_mismatch("in use", bytes_in_use_o, w.used);
        if (bytes_available_o !== w.avail)
          report_mismatch("available", bytes_available_o, w.avail);
        if (peak_bytes_o !== w.peak) report_mismatch("peak", peak_bytes_o, w.peak);
        if (allocation_count_o !== w.acnt)
          report_mismatch("alloc count", allocation_count_o, w.acnt);
        if (release_count_o !== w.rcnt)
          report_mismatch("release count", release_count_o, w.rcnt);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] align,
                           logic [OFF_W-1:0] roff, bit typed, row_t r);
    grant_t g;
    in_valid_i <= 1'b1;
    operation_i <= op;
    request_size_i <= size;
    alignment_i <= align;
    release_offset_i <= roff;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    g = predict_grant(op, size, align, roff);
    if (typed) begin
      g.st = r.st;
      g.off = r.goff;
      g.sz = r.gsz;
    end
    pending_grants = {pending_grants, g};
    if ($urandom_range(0, 99) < tx_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_levels(logic [CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_pool_levels_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pool_restart(v);
  endtask

  task automatic random_traffic(int count);
    row_t none;
    logic op;
    logic [SIZE_W-1:0] size, align;
    logic [OFF_W-1:0] roff;
    int unsigned pick;
    none = '{default: 0, st: ST_OK};
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      op = (live_offsets.size() > 0 && pick < 45) || pick >= 92 ? OP_RELEASE : OP_ALLOC;
      if (pick < 85) size = SIZE_W'($urandom_range(1, MINB << $urandom_range(0, lvls - 1)));
      else size = SIZE_W'($urandom);
      case ($urandom_range(0, 5))
        0: align = '0;
        1: align = SIZE_W'($urandom);
        2: align = SIZE_W'($urandom_range(1, 700));
        default: align = SIZE_W'(1 << $urandom_range(0, 19));
      endcase
      if (live_offsets.size() > 0 && $urandom_range(0, 99) < 80)
        roff = OFF_W'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
      else if ($urandom_range(0, 1))
        roff = OFF_W'($urandom_range(0, 2047) * MINB);
      else
        roff = OFF_W'($urandom);
      send_item(op, size, align, roff, 0, none);
    end
  endtask

  row_t dir_rows [$];

  initial begin
    logic [CFG_W-1:0] lv_list [$];
    pool_restart(CFG_W'(POOL_LEVELS_RST));
    dir_rows = '{
      '{OP_ALLOC, 0, 1, 0, 1, ST_BAD_SIZE, 0, 0},
      '{OP_ALLOC, 20'hFFFFF, 1, 0, 1, ST_BAD_SIZE, 0, 0},
      '{OP_ALLOC, 20'h80001, 1, 0, 1, ST_BAD_SIZE, 0, 0},
      '{OP_RELEASE, 0, 1, 0, 1, ST_BAD_OFFSET, 0, 0},
      '{OP_RELEASE, 0, 1, 19'h7FFFF, 1, ST_BAD_OFFSET, 0, 0},
      '{OP_RELEASE, 0, 1, 1, 1, ST_BAD_OFFSET, 0, 0},
      '{OP_ALLOC, 20'h80000, 1, 0, 1, ST_OK, 0, 20'h80000},
      '{OP_ALLOC, 1, 1, 0, 1, ST_NO_MEM, 0, 0},
      '{OP_RELEASE, 0, 1, 0, 1, ST_OK, 0, 20'h80000},
      '{OP_ALLOC, 1, 0, 0, 1, ST_OK, 0, 256},
      '{OP_ALLOC, 1, 20'hFFFFF, 0, 1, ST_BAD_SIZE, 0, 0},
      '{OP_ALLOC, 300, 512, 0, 0, ST_OK, 0, 0},
      '{OP_ALLOC, 256, 1, 0, 0, ST_OK, 0, 0},
      '{OP_ALLOC, 20'h40000, 20'h40000, 0, 0, ST_OK, 0, 0},
      '{OP_RELEASE, 0, 1, 256, 0, ST_OK, 0, 0},
      '{OP_RELEASE, 0, 1, 256, 0, ST_OK, 0, 0},
      '{OP_RELEASE, 0, 1, 512, 0, ST_OK, 0, 0},
      '{OP_RELEASE, 0, 1, 0, 0, ST_OK, 0, 0},
      '{OP_RELEASE, 0, 1, 19'h40000, 0, ST_OK, 0, 0},
      '{OP_ALLOC, 20'h80000, 20'h80000, 0, 0, ST_OK, 0, 0},
      '{OP_RELEASE, 20'hFFFFF, 20'hFFFFF, 0, 0, ST_OK, 0, 0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle = 20;
    rx_idle = 47;
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].size, dir_rows[i].align, dir_rows[i].off,
                dir_rows[i].typed, dir_rows[i]);
    random_traffic(150);
    hold_go = 1;
    random_traffic(60);
    lv_list = '{1, 12, 0, 15, 3, 7, 4'($urandom_range(2, 11))};
    foreach (lv_list[i]) begin
      if (i == 2) begin
        tx_idle = 47;
        rx_idle = 20;
      end else if (i == 5) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      write_levels(lv_list[i]);
      random_traffic(155);
    end
    in_valid_i <= 1'b0;
    drain_results();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
